// ----- sv/aor_pkg.sv -----
// Shared widths, types and codes for the box overlap resolve pipeline.
package aor_pkg;

  localparam int COORD_W = 24;
  localparam int SIZE_W  = COORD_W - 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SUM_W   = SIZE_W + 1;
  localparam int OV_W    = COORD_W + 3;
  localparam int NSTAGE  = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0] size_t_t;
  typedef logic signed [OV_W-1:0] ov_t;

  typedef enum logic [2:0] {
    SIDE_NONE  = 3'd0,
    SIDE_LEFT  = 3'd1,
    SIDE_RIGHT = 3'd2,
    SIDE_DOWN  = 3'd3,
    SIDE_UP    = 3'd4
  } side_t;

  typedef struct packed {
    ov_t    ov2;
    logic   lt;
    coord_t pa;
  } axis_t;

endpackage

// ----- sv/aor_axis.sv -----
// Three-stage per-axis doubled overlap: difference and size sum, magnitude, overlap.
module aor_axis (
  input  logic              clk,
  input  logic [2:0]        en,
  input  aor_pkg::coord_t   pa,
  input  aor_pkg::coord_t   pb,
  input  aor_pkg::size_t_t  sa,
  input  aor_pkg::size_t_t  sb,
  output aor_pkg::axis_t    axis
);

  logic signed [aor_pkg::DIFF_W-1:0] diff_r;
  logic [aor_pkg::SUM_W-1:0]         sum0_r;
  aor_pkg::coord_t                   pa0_r;

  logic [aor_pkg::DIFF_W-1:0]        mag_r;
  logic [aor_pkg::SUM_W-1:0]         sum1_r;
  logic                              lt1_r;
  aor_pkg::coord_t                   pa1_r;

  aor_pkg::axis_t                    axis_r;

  logic [aor_pkg::DIFF_W-1:0]        mag_nxt;
  aor_pkg::ov_t                      ov_nxt;

  always_comb begin
    mag_nxt = diff_r[aor_pkg::DIFF_W-1] ? aor_pkg::DIFF_W'(-diff_r) : aor_pkg::DIFF_W'(diff_r);
    ov_nxt  = aor_pkg::ov_t'({{(aor_pkg::OV_W-aor_pkg::SUM_W){1'b0}}, sum1_r})
            - aor_pkg::ov_t'({{(aor_pkg::OV_W-aor_pkg::DIFF_W-1){1'b0}}, mag_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r <= aor_pkg::DIFF_W'(pb) - aor_pkg::DIFF_W'(pa);
      sum0_r <= aor_pkg::SUM_W'(sa) + aor_pkg::SUM_W'(sb);
      pa0_r  <= pa;
    end
    if (en[1]) begin
      mag_r  <= mag_nxt;
      sum1_r <= sum0_r;
      lt1_r  <= diff_r[aor_pkg::DIFF_W-1];
      pa1_r  <= pa0_r;
    end
    if (en[2]) begin
      axis_r.ov2 <= ov_nxt;
      axis_r.lt  <= lt1_r;
      axis_r.pa  <= pa1_r;
    end
  end

  assign axis = axis_r;

endmodule

// ----- sv/aor_resolve.sv -----
// Axis choice, contact side and depth, then saturated push-out into the output register.
module aor_resolve (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        en,
  input  logic              valid,
  input  aor_pkg::axis_t    ax_in,
  input  aor_pkg::axis_t    ay_in,
  input  logic              trig,
  output logic              hit,
  output logic              trigger_only,
  output aor_pkg::side_t    contact_side,
  output aor_pkg::size_t_t  depth,
  output aor_pkg::coord_t   new_x,
  output aor_pkg::coord_t   new_y
);

  // decision stage
  logic              hit_r, tonly_r, xsel_r;
  aor_pkg::side_t    side_r;
  aor_pkg::size_t_t  depth_r;
  aor_pkg::coord_t   px_r, py_r;

  // output stage
  logic              hit_o_r, tonly_o_r;
  aor_pkg::side_t    side_o_r;
  aor_pkg::size_t_t  depth_o_r;
  aor_pkg::coord_t   nx_r, ny_r;

  logic              hit_nxt, tonly_nxt, xsel_nxt;
  aor_pkg::side_t    side_nxt;
  aor_pkg::size_t_t  depth_nxt;
  aor_pkg::ov_t      ov_sel, ov_half;

  logic signed [aor_pkg::DIFF_W-1:0] pos_ext, dep_ext, push;
  aor_pkg::coord_t   pushed, nx_nxt, ny_nxt;

  always_comb begin
    hit_nxt  = !ax_in.ov2[aor_pkg::OV_W-1] && !ay_in.ov2[aor_pkg::OV_W-1];
    xsel_nxt = ax_in.ov2 < ay_in.ov2;
    ov_sel   = xsel_nxt ? ax_in.ov2 : ay_in.ov2;
    ov_half  = (ov_sel + aor_pkg::ov_t'(1)) >>> 1;
    if (ov_half[aor_pkg::OV_W-1:aor_pkg::SIZE_W] != '0) begin
      depth_nxt = '1;
    end else begin
      depth_nxt = ov_half[aor_pkg::SIZE_W-1:0];
    end
    tonly_nxt = 1'b0;
    side_nxt  = aor_pkg::SIDE_NONE;
    if (hit_nxt) begin
      if (xsel_nxt) begin
        if (trig) begin
          tonly_nxt = 1'b1;
        end else begin
          side_nxt = ax_in.lt ? aor_pkg::SIDE_LEFT : aor_pkg::SIDE_RIGHT;
        end
      end else begin
        priority if (ay_in.lt) begin
          side_nxt = aor_pkg::SIDE_DOWN;
        end else if (trig) begin
          tonly_nxt = 1'b1;
        end else begin
          side_nxt = aor_pkg::SIDE_UP;
        end
      end
    end
    if (side_nxt == aor_pkg::SIDE_NONE) begin
      depth_nxt = '0;
    end
  end

  always_comb begin
    pos_ext = xsel_r ? aor_pkg::DIFF_W'(px_r) : aor_pkg::DIFF_W'(py_r);
    dep_ext = aor_pkg::DIFF_W'({1'b0, depth_r});
    if (side_r == aor_pkg::SIDE_LEFT || side_r == aor_pkg::SIDE_DOWN) begin
      push = pos_ext + dep_ext;
    end else begin
      push = pos_ext - dep_ext;
    end
    if (push[aor_pkg::DIFF_W-1] != push[aor_pkg::COORD_W-1]) begin
      pushed = push[aor_pkg::DIFF_W-1] ? {1'b1, {(aor_pkg::COORD_W-1){1'b0}}}
                                       : {1'b0, {(aor_pkg::COORD_W-1){1'b1}}};
    end else begin
      pushed = push[aor_pkg::COORD_W-1:0];
    end
    nx_nxt = px_r;
    ny_nxt = py_r;
    unique case (side_r)
      aor_pkg::SIDE_LEFT, aor_pkg::SIDE_RIGHT: nx_nxt = pushed;
      aor_pkg::SIDE_DOWN, aor_pkg::SIDE_UP:    ny_nxt = pushed;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hit_r   <= hit_nxt;
      tonly_r <= tonly_nxt;
      xsel_r  <= xsel_nxt;
      side_r  <= side_nxt;
      depth_r <= depth_nxt;
      px_r    <= ax_in.pa;
      py_r    <= ay_in.pa;
    end
    if (en[1]) begin
      hit_o_r   <= hit_r;
      tonly_o_r <= tonly_r;
      side_o_r  <= side_r;
      depth_o_r <= depth_r;
      nx_r      <= nx_nxt;
      ny_r      <= ny_nxt;
    end
  end

  assign hit          = hit_o_r;
  assign trigger_only = tonly_o_r;
  assign contact_side = side_o_r;
  assign depth        = depth_o_r;
  assign new_x        = nx_r;
  assign new_y        = ny_r;

`ifndef NO_ASSERTIONS
  a_nohit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid && en[1] && !hit_r |=> !hit_o_r && side_o_r == aor_pkg::SIDE_NONE
      && depth_o_r == '0 && !tonly_o_r)
    else $error("non-hit carries a resolution");
  a_tonly_unresolved: assert property (@(posedge clk) disable iff (!rst_n)
    valid && tonly_r |-> hit_r && side_r == aor_pkg::SIDE_NONE && depth_r == '0)
    else $error("trigger-only beat has a side or depth");
  a_side_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    valid && side_r != aor_pkg::SIDE_NONE |-> hit_r && !tonly_r)
    else $error("contact side without hit");
  a_x_side_axis: assert property (@(posedge clk) disable iff (!rst_n)
    valid && (side_r == aor_pkg::SIDE_LEFT || side_r == aor_pkg::SIDE_RIGHT) |-> xsel_r)
    else $error("x side on y-resolved beat");
`endif

endmodule

// ----- sv/aor_top_note.sv -----
// Valid-bit chain and per-stage enables for the five-stage box resolve pipeline.
module aor_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        out_ready,
  output logic                        in_ready,
  output logic [aor_pkg::NSTAGE-1:0]  en,
  output logic [aor_pkg::NSTAGE-1:0]  vld
);

  logic [aor_pkg::NSTAGE-1:0] v_r, v_nxt;

  always_comb begin
    en[aor_pkg::NSTAGE-1] = !v_r[aor_pkg::NSTAGE-1] || out_ready;
    for (int k = aor_pkg::NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < aor_pkg::NSTAGE; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];
  assign vld      = v_r;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted beat not in first stage");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[aor_pkg::NSTAGE-1] && !out_ready |=> v_r[aor_pkg::NSTAGE-1])
    else $error("stalled result lost");
  a_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[aor_pkg::NSTAGE-2] && out_ready |=> !v_r[aor_pkg::NSTAGE-1])
    else $error("result repeated");
`endif

endmodule

// ----- sv/aabb_overlap_resolve.sv -----
// Top level: two-box minimum-penetration test and push-out, five-stage pipeline.
//
//  channel  handshake              payload
//  in_      in_valid / in_ready    a_x a_y a_width a_height b_x b_y b_width b_height triggers
//  out_     out_valid / out_ready  hit trigger_only contact_side depth new_a_x new_a_y
//
// One beat per cycle sustained while out_ready stays high; out_valid rises once the beat reaches the last stage.
// Stages: difference and size sum, magnitude, doubled overlap, axis choice, push and saturate.
// Each stage holds its beat until the next stage frees, so bubbles close up under a stall.
// Reset clears only the valid bits; the pipeline is empty after reset.
module aabb_overlap_resolve (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  aor_pkg::coord_t         in_a_x,
  input  aor_pkg::coord_t         in_a_y,
  input  aor_pkg::size_t_t        in_a_width,
  input  aor_pkg::size_t_t        in_a_height,
  input  aor_pkg::coord_t         in_b_x,
  input  aor_pkg::coord_t         in_b_y,
  input  aor_pkg::size_t_t        in_b_width,
  input  aor_pkg::size_t_t        in_b_height,
  input  logic                    in_a_is_trigger,
  input  logic                    in_b_is_trigger,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic                    out_trigger_only,
  output logic [2:0]              out_contact_side,
  output aor_pkg::size_t_t        out_depth,
  output aor_pkg::coord_t         out_new_a_x,
  output aor_pkg::coord_t         out_new_a_y
);

  logic [aor_pkg::NSTAGE-1:0] en, vld;
  aor_pkg::axis_t             ax, ay;
  aor_pkg::side_t             side;
  logic                       trig0_r, trig1_r, trig2_r;

  aor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .en        (en),
    .vld       (vld)
  );

  aor_axis u_axis_x (
    .clk  (clk),
    .en   (en[2:0]),
    .pa   (in_a_x),
    .pb   (in_b_x),
    .sa   (in_a_width),
    .sb   (in_b_width),
    .axis (ax)
  );

  aor_axis u_axis_y (
    .clk  (clk),
    .en   (en[2:0]),
    .pa   (in_a_y),
    .pb   (in_b_y),
    .sa   (in_a_height),
    .sb   (in_b_height),
    .axis (ay)
  );

  always_ff @(posedge clk) begin
    if (en[0]) trig0_r <= in_a_is_trigger | in_b_is_trigger;
    if (en[1]) trig1_r <= trig0_r;
    if (en[2]) trig2_r <= trig1_r;
  end

  aor_resolve u_resolve (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en[4:3]),
    .valid        (vld[3]),
    .ax_in        (ax),
    .ay_in        (ay),
    .trig         (trig2_r),
    .hit          (out_hit),
    .trigger_only (out_trigger_only),
    .contact_side (side),
    .depth        (out_depth),
    .new_x        (out_new_a_x),
    .new_y        (out_new_a_y)
  );

  assign out_contact_side = side;
  assign out_valid        = vld[aor_pkg::NSTAGE-1];

endmodule
